// ===== design/llpm_pkg.sv =====
// package with field widths, operation kinds and status codes of the list pool manager
`default_nettype none
package llpm_pkg;
    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 6;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int POP_W    = 32;
    localparam int LENGTH_W = 7;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND     = 3'd0,
        K_PREPEND    = 3'd1,
        K_INSERT     = 3'd2,
        K_POP        = 3'd3,
        K_REMOVE     = 3'd4,
        K_MOVE       = 3'd5,
        K_REMOVE_VAL = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_HANDLE = 3'd4
    } t_status;
endpackage
`default_nettype wire

// ===== design/llpm_if.sv =====
// valid/ready channel interfaces for operations and results
`default_nettype none
interface llpm_in_if;
    import llpm_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [PAY_W-1:0]    payload;
    modport source (output valid, kind, handle, payload, input ready);
    modport sink   (input valid, kind, handle, payload, output ready);
endinterface

interface llpm_out_if;
    import llpm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  node_index;
    logic [POP_W-1:0]    popped_data;
    logic [LENGTH_W-1:0] length;
    modport source (output valid, status, node_index, popped_data, length, input ready);
    modport sink   (input valid, status, node_index, popped_data, length, output ready);
endinterface
`default_nettype wire

// ===== design/linked_list_pool_manager.sv =====
// doubly linked list in a node pool with a lifo free list, memory based sequencer
//
// Operations arrive on i_in (kind, handle, payload); each gives exactly one
// result on o_out (status, node_index, popped_data, length). A transfer
// happens when valid and ready are both high.
// One operation is worked at a time. Node data, next links, previous links
// and list flags sit in synchronous memories with a registered read; a small
// sequencer reads, then writes the links of the node and its neighbors.
// Remove by value walks the list node by node from the head until a match
// or the end; move front of a node that is already the head writes no links.
// The next operation is taken in the cycle after the result is loaded.
// Reset clears head, tail, free head, count and the fill mark;
// nodes above the fill mark have never been used and join the free chain in
// order, so no memory clearing pass is needed.
// When the receiver stalls the result holds in the output register; the
// next operation is accepted and worked, and waits before its result until
// the register frees.
`default_nettype none
module linked_list_pool_manager #(
    parameter int POOL_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    llpm_in_if.sink       i_in,
    llpm_out_if.source    o_out
);
    import llpm_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOOK   = 9'b000000010,
        S_ALLOC  = 9'b000000100,
        S_WALK   = 9'b000001000,
        S_UNLINK = 9'b000010000,
        S_FREE   = 9'b000100000,
        S_FRONT  = 9'b001000000,
        S_FIX    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    logic [LW-1:0]         m_nxt [POOL_DEPTH];
    logic [LW-1:0]         m_prv [POOL_DEPTH];
    logic                  m_inl [POOL_DEPTH];
    logic [DATA_WIDTH-1:0] m_dat [POOL_DEPTH];

    logic [LW-1:0]         r_rd_nxt, r_rd_prv;
    logic                  r_rd_inl;
    logic [DATA_WIDTH-1:0] r_rd_dat;

    t_state  r_state, n_state;
    logic [LW-1:0] r_head, n_head, r_tail, n_tail, r_fh, n_fh, r_fill, n_fill;
    logic [LW-1:0] r_count, n_count;
    logic    r_ov, n_ov;

    t_kind   r_kind, n_kind;
    logic [LW-1:0] r_h, n_h, r_n, n_n, r_p, n_p, r_x, n_x, r_idx, n_idx;
    logic    r_h_ok, n_h_ok;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic [DATA_WIDTH-1:0] r_pop, n_pop;
    t_status r_st, n_st;
    t_status r_o_st, n_o_st;
    logic [INDEX_W-1:0]  r_o_idx, n_o_idx;
    logic [POP_W-1:0]    r_o_pop, n_o_pop;
    logic [LENGTH_W-1:0] r_o_len, n_o_len;

    logic [IW-1:0] ra;
    logic          we_nxt, we_prv, we_inl, we_dat;
    logic [IW-1:0] wa_nxt, wa_prv, wa_inl, wa_dat;
    logic [LW-1:0] wd_nxt, wd_prv;
    logic          wd_inl;
    logic          live;

    assign i_in.ready        = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid       = r_ov;
    assign o_out.status      = r_o_st;
    assign o_out.node_index  = r_o_idx;
    assign o_out.popped_data = r_o_pop;
    assign o_out.length      = r_o_len;

    assign live = r_h_ok && (r_h < r_fill) && r_rd_inl;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_fh    = r_fh;
        n_fill  = r_fill;
        n_count = r_count;
        n_ov    = r_ov;
        n_kind  = r_kind;
        n_h     = r_h;
        n_h_ok  = r_h_ok;
        n_pay   = r_pay;
        n_n     = r_n;
        n_p     = r_p;
        n_x     = r_x;
        n_idx   = r_idx;
        n_pop   = r_pop;
        n_st    = r_st;
        n_o_st  = r_o_st;
        n_o_idx = r_o_idx;
        n_o_pop = r_o_pop;
        n_o_len = r_o_len;
        ra      = '0;
        we_nxt  = 1'b0;
        we_prv  = 1'b0;
        we_inl  = 1'b0;
        we_dat  = 1'b0;
        wa_nxt  = '0;
        wa_prv  = '0;
        wa_inl  = '0;
        wa_dat  = '0;
        wd_nxt  = '0;
        wd_prv  = '0;
        wd_inl  = 1'b0;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                case (t_kind'(i_in.kind))
                    K_INSERT, K_REMOVE, K_MOVE: ra = IW'(i_in.handle);
                    K_POP, K_REMOVE_VAL:        ra = r_head[IW-1:0];
                    default:                    ra = r_fh[IW-1:0];
                endcase
                if (i_in.valid) begin
                    n_kind = t_kind'(i_in.kind);
                    n_h    = LW'(i_in.handle);
                    n_h_ok = (32'(i_in.handle) < 32'(POOL_DEPTH));
                    n_pay  = i_in.payload;
                    n_idx  = '0;
                    n_pop  = '0;
                    n_st   = ST_OK;
                    n_n    = r_head;
                    case (t_kind'(i_in.kind))
                        K_APPEND, K_PREPEND:                n_state = S_ALLOC;
                        K_INSERT, K_POP, K_REMOVE, K_MOVE:  n_state = S_LOOK;
                        K_REMOVE_VAL:                       n_state = S_WALK;
                        default:                            n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
                case (r_kind)
                    K_INSERT: begin
                        if (!live) begin
                            n_st = ST_BAD_HANDLE;
                        end else begin
                            n_p     = r_rd_prv;
                            n_x     = r_h;
                            ra      = r_fh[IW-1:0];
                            n_state = S_ALLOC;
                        end
                    end
                    K_POP: begin
                        if (r_head == NONE) begin
                            n_st = ST_EMPTY;
                        end else begin
                            n_n     = r_head;
                            n_p     = r_rd_prv;
                            n_x     = r_rd_nxt;
                            n_pop   = r_rd_dat;
                            n_state = S_UNLINK;
                        end
                    end
                    K_REMOVE, K_MOVE: begin
                        if (!live) begin
                            n_st = ST_BAD_HANDLE;
                        end else if (r_kind == K_MOVE && r_h == r_head) begin
                            n_idx = r_h;
                        end else begin
                            n_n     = r_h;
                            n_p     = r_rd_prv;
                            n_x     = r_rd_nxt;
                            n_state = S_UNLINK;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ALLOC: begin
                if (r_fh == NONE) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_n     = r_fh;
                    if (r_fh == r_fill) begin
                        n_fh   = r_fh + LW'(1);
                        n_fill = r_fill + LW'(1);
                    end else begin
                        n_fh = r_rd_nxt;
                    end
                    we_inl  = 1'b1;
                    wa_inl  = r_fh[IW-1:0];
                    wd_inl  = 1'b1;
                    we_dat  = 1'b1;
                    wa_dat  = r_fh[IW-1:0];
                    n_count = r_count + LW'(1);
                    we_nxt  = 1'b1;
                    wa_nxt  = r_fh[IW-1:0];
                    we_prv  = 1'b1;
                    wa_prv  = r_fh[IW-1:0];
                    case (r_kind)
                        K_APPEND: begin
                            wd_nxt = NONE;
                            wd_prv = r_tail;
                            n_x    = r_tail;
                            n_tail = r_fh;
                            if (r_tail == NONE) n_head = r_fh;
                        end
                        K_PREPEND: begin
                            wd_nxt = r_head;
                            wd_prv = NONE;
                            n_x    = r_head;
                            n_head = r_fh;
                            if (r_head == NONE) n_tail = r_fh;
                        end
                        default: begin
                            wd_nxt = r_x;
                            wd_prv = r_p;
                            if (r_p == NONE) n_head = r_fh;
                        end
                    endcase
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                case (r_kind)
                    K_APPEND: begin
                        we_nxt = (r_x != NONE);
                        wa_nxt = r_x[IW-1:0];
                        wd_nxt = r_n;
                    end
                    K_INSERT: begin
                        we_prv = 1'b1;
                        wa_prv = r_x[IW-1:0];
                        wd_prv = r_n;
                        we_nxt = (r_p != NONE);
                        wa_nxt = r_p[IW-1:0];
                        wd_nxt = r_n;
                    end
                    default: begin
                        we_prv = (r_x != NONE);
                        wa_prv = r_x[IW-1:0];
                        wd_prv = r_n;
                    end
                endcase
                n_idx   = r_n;
                n_state = S_DONE;
            end
            S_WALK: begin
                if (r_n == NONE) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else if (64'(r_rd_dat) == 64'(r_pay)) begin
                    n_p     = r_rd_prv;
                    n_x     = r_rd_nxt;
                    n_state = S_UNLINK;
                end else begin
                    n_n = r_rd_nxt;
                    ra  = r_rd_nxt[IW-1:0];
                end
            end
            S_UNLINK: begin
                if (r_p != NONE) begin
                    we_nxt = 1'b1;
                    wa_nxt = r_p[IW-1:0];
                    wd_nxt = r_x;
                end else begin
                    n_head = r_x;
                end
                if (r_x != NONE) begin
                    we_prv = 1'b1;
                    wa_prv = r_x[IW-1:0];
                    wd_prv = r_p;
                end else begin
                    n_tail = r_p;
                end
                n_state = (r_kind == K_MOVE) ? S_FRONT : S_FREE;
            end
            S_FREE: begin
                we_inl  = 1'b1;
                wa_inl  = r_n[IW-1:0];
                wd_inl  = 1'b0;
                we_prv  = 1'b1;
                wa_prv  = r_n[IW-1:0];
                wd_prv  = NONE;
                we_nxt  = 1'b1;
                wa_nxt  = r_n[IW-1:0];
                wd_nxt  = r_fh;
                n_fh    = r_n;
                n_count = r_count - LW'(1);
                n_idx   = r_n;
                n_state = S_DONE;
            end
            S_FRONT: begin
                we_nxt  = 1'b1;
                wa_nxt  = r_n[IW-1:0];
                wd_nxt  = r_head;
                we_prv  = 1'b1;
                wa_prv  = r_n[IW-1:0];
                wd_prv  = NONE;
                n_x     = r_head;
                n_head  = r_n;
                n_state = S_FIX;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_o_st  = r_st;
                    n_o_idx = INDEX_W'(r_idx);
                    n_o_pop = POP_W'(r_pop);
                    n_o_len = LENGTH_W'(r_count);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NONE;
            r_tail  <= NONE;
            r_fh    <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fh    <= n_fh;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_h     <= n_h;
        r_h_ok  <= n_h_ok;
        r_pay   <= n_pay;
        r_n     <= n_n;
        r_p     <= n_p;
        r_x     <= n_x;
        r_idx   <= n_idx;
        r_pop   <= n_pop;
        r_st    <= n_st;
        r_o_st  <= n_o_st;
        r_o_idx <= n_o_idx;
        r_o_pop <= n_o_pop;
        r_o_len <= n_o_len;
    end

    always_ff @(posedge i_clk) begin
        if (we_nxt) m_nxt[wa_nxt] <= wd_nxt;
        r_rd_nxt <= m_nxt[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_prv) m_prv[wa_prv] <= wd_prv;
        r_rd_prv <= m_prv[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_inl) m_inl[wa_inl] <= wd_inl;
        r_rd_inl <= m_inl[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_dat) m_dat[wa_dat] <= DATA_WIDTH'(r_pay);
        r_rd_dat <= m_dat[ra];
    end
endmodule
`default_nettype wire

// ===== design/llpm_checker.sv =====
// port level checks of the list pool manager and their bind
`default_nettype none
module llpm_checker #(
    parameter int POOL_DEPTH = 64
) (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [llpm_pkg::STATUS_W-1:0]  i_out_status,
    input wire [llpm_pkg::INDEX_W-1:0]   i_out_index,
    input wire [llpm_pkg::POP_W-1:0]     i_out_popped,
    input wire [llpm_pkg::LENGTH_W-1:0]  i_out_length
);
    import llpm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_index) && $stable(i_out_length))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second operation taken while one is in work");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_out_length) <= POOL_DEPTH)
        else $error("length above pool depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> (i_out_index == '0) && (i_out_popped == '0))
        else $error("error result carries index or data");
endmodule

bind linked_list_pool_manager llpm_checker #(.POOL_DEPTH(POOL_DEPTH)) u_llpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_index  (o_out.node_index),
    .i_out_popped (o_out.popped_data),
    .i_out_length (o_out.length)
);
`default_nettype wire

// ===== test/llpm_checker.sv =====
// checker: predicts list pool results from observed operation transfers and compares them
`timescale 1ns / 100ps
module llpm_scoreboard (
    input  wire         i_clk,
    input  wire         i_rst_n,
    llpm_in_if          i_in,
    llpm_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending
);
    import llpm_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [6:0] NIL = 7'd64;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  node_index;
        logic [POP_W-1:0]    popped_data;
        logic [LENGTH_W-1:0] length;
    } t_result;

    logic [31:0] pool_data [DEPTH];
    logic [6:0]  nxt [DEPTH];
    logic [6:0]  prv [DEPTH];
    logic        used [DEPTH];
    logic [6:0]  head, tail, free_top, count;
    t_result     pending_results [$];
    int          fails;
    int          pend_cnt;

    assign o_fail_count = fails;
    assign o_pending    = pend_cnt;

    function automatic bit is_live(logic [6:0] n);
        return n < NIL && used[n[5:0]];
    endfunction

    task automatic detach(logic [6:0] n);
        logic [6:0] p, x;
        p = prv[n[5:0]];
        x = nxt[n[5:0]];
        if (p < NIL) nxt[p[5:0]] = x; else head = x;
        if (x < NIL) prv[x[5:0]] = p; else tail = p;
    endtask

    task automatic release_node(logic [6:0] n);
        used[n[5:0]] = 1'b0;
        prv[n[5:0]]  = NIL;
        nxt[n[5:0]]  = free_top;
        free_top     = n;
        count        = count - 7'd1;
    endtask

    task automatic attach_front(logic [6:0] n);
        prv[n[5:0]] = NIL;
        nxt[n[5:0]] = head;
        if (head < NIL) prv[head[5:0]] = n; else tail = n;
        head = n;
    endtask

    task automatic apply_op(logic [2:0] kind, logic [5:0] h, logic [31:0] pay);
        t_result    r;
        logic [6:0] n, hh;
        int         steps;
        r  = '0;
        hh = {1'b0, h};
        case (kind)
            K_APPEND, K_PREPEND, K_INSERT: begin
                if (kind == K_INSERT && !is_live(hh)) begin
                    r.status = ST_BAD_HANDLE;
                end else if (free_top >= NIL) begin
                    r.status = ST_FULL;
                end else begin
                    n = free_top;
                    free_top = nxt[n[5:0]];
                    used[n[5:0]] = 1'b1;
                    count = count + 7'd1;
                    pool_data[n[5:0]] = pay;
                    if (kind == K_APPEND) begin
                        nxt[n[5:0]] = NIL;
                        prv[n[5:0]] = tail;
                        if (tail < NIL) nxt[tail[5:0]] = n; else head = n;
                        tail = n;
                    end else if (kind == K_PREPEND) begin
                        attach_front(n);
                    end else begin
                        prv[n[5:0]] = prv[h];
                        nxt[n[5:0]] = hh;
                        if (prv[h] < NIL) nxt[prv[h][5:0]] = n; else head = n;
                        prv[h] = n;
                    end
                    r.node_index = n[5:0];
                end
            end
            K_POP: begin
                n = head;
                if (!is_live(n)) begin
                    r.status = ST_EMPTY;
                end else begin
                    detach(n);
                    r.popped_data = pool_data[n[5:0]];
                    release_node(n);
                    r.node_index = n[5:0];
                end
            end
            K_REMOVE: begin
                if (!is_live(hh)) r.status = ST_BAD_HANDLE;
                else begin
                    detach(hh);
                    release_node(hh);
                    r.node_index = h;
                end
            end
            K_MOVE: begin
                if (!is_live(hh)) r.status = ST_BAD_HANDLE;
                else begin
                    if (head != hh) begin
                        detach(hh);
                        attach_front(hh);
                    end
                    r.node_index = h;
                end
            end
            K_REMOVE_VAL: begin
                r.status = ST_NOT_FOUND;
                n = head;
                for (steps = 0; steps < DEPTH && is_live(n); steps++) begin
                    if (pool_data[n[5:0]] == pay) begin
                        detach(n);
                        release_node(n);
                        r.node_index = n[5:0];
                        r.status = ST_OK;
                        break;
                    end
                    n = nxt[n[5:0]];
                end
            end
            default: ;
        endcase
        r.length = count;
        pending_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                nxt[i]  = 7'(i + 1);
                prv[i]  = NIL;
                used[i] = 1'b0;
                pool_data[i] = '0;
            end
            head = NIL;
            tail = NIL;
            free_top = '0;
            count = '0;
            pending_results.delete();
            pend_cnt = 0;
            fails = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.status, i_out.node_index, i_out.popped_data, i_out.length};
                if (pending_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: status %0d/%0d index %0d/%0d data %h/%h len %0d/%0d",
                                want.status, got.status, want.node_index, got.node_index,
                                want.popped_data, got.popped_data, want.length, got.length);
                    end
                end
            end
            if (i_in.valid && i_in.ready) apply_op(i_in.kind, i_in.handle, i_in.payload);
            pend_cnt = pending_results.size();
        end
    end
endmodule

// ===== test/linked_list_pool_manager_tb.sv =====
// testbench top: drives list operations with random idling and gives the verdict
`timescale 1ns / 100ps
module linked_list_pool_manager_tb;
    import llpm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, idle_cycles;
    bit   rx_gaps = 1'b1, long_stall = 1'b0;
    logic [31:0] recent_data [$];

    llpm_in_if  in_ch ();
    llpm_out_if out_ch ();

    linked_list_pool_manager u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    llpm_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.handle = '0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // receiver with random bursts of back-pressure
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                out_ch.ready <= 1'b0;
                for (n = 0; n < 300; n++) @(negedge i_clk);
                long_stall = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("linked_list_pool_manager regression: fail");
            $finish;
        end
    end

    task automatic send(logic [2:0] kind, logic [5:0] h, logic [31:0] pay);
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.handle  <= h;
        in_ch.payload <= pay;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (kind <= K_INSERT) begin
            recent_data.push_back(pay);
            if (recent_data.size() > 16) void'(recent_data.pop_front());
        end
    endtask

    task automatic send_random(bit tx_gaps, int bias);
        logic [2:0]  kind;
        logic [5:0]  h;
        logic [31:0] pay;
        int r;
        r = $urandom_range(0, 99);
        if (r < bias) kind = 3'($urandom_range(0, 2));
        else kind = 3'($urandom_range(0, 7));
        h = 6'($urandom);
        pay = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
        if (kind == K_REMOVE_VAL && recent_data.size() > 0 && $urandom_range(0, 2) != 0)
            pay = recent_data[$urandom_range(0, recent_data.size() - 1)];
        send(kind, h, pay);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send(K_POP, 6'd0, 32'd0);
        send(K_REMOVE_VAL, 6'd0, 32'd5);
        send(K_REMOVE, 6'd0, 32'd0);
        send(K_MOVE, 6'd63, 32'd0);
        send(K_INSERT, 6'd3, 32'd1);
        send(K_APPEND, 6'd0, 32'hFFFF_FFFF);
        send(K_PREPEND, 6'd63, 32'h0000_0000);
        send(K_INSERT, 6'd0, 32'hA5A5_5A5A);
        send(K_APPEND, 6'd0, 32'h1234_5678);
        send(K_MOVE, 6'd2, 32'd0);
        send(K_MOVE, 6'd2, 32'd0);
        send(K_MOVE, 6'd3, 32'd0);
        send(K_REMOVE_VAL, 6'd0, 32'h1234_5678);
        send(K_REMOVE_VAL, 6'd0, 32'h7777_7777);
        send(3'd7, 6'h2A, 32'h5555_AAAA);
        send(K_REMOVE, 6'd1, 32'd0);
        send(K_REMOVE, 6'd1, 32'd0);
        send(K_POP, 6'd0, 32'd0);
        send(K_POP, 6'd0, 32'd0);
        repeat (66) send(K_APPEND, 6'd0, $urandom);
        send(K_INSERT, 6'd5, 32'd9);
        drain();
        for (int i = 0; i < 70; i++) send_random(1'b1, 20);
        drain();
        for (int i = 0; i < 90; i++) send_random(1'b1, 55);
        long_stall = 1'b1;
        for (int i = 0; i < 20; i++) send_random(1'b0, 50);
        drain();
        for (int i = 0; i < 90; i++) send_random(1'b1, 40);
        rx_gaps = 1'b0;
        for (int i = 0; i < 70; i++) send_random(1'b0, 40);
        drain();
        if (fail_count == 0 && pending == 0)
            $display("linked_list_pool_manager regression: pass");
        else
            $display("linked_list_pool_manager regression: fail");
        $finish;
    end
endmodule
